// ----- design/bounded_deque_with_search_delete_unit_macros.svh -----
// Shared assertion macros for the deque unit checkers.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_DELETE_UNIT_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_DELETE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bdq_pkg.sv -----
package bdq_pkg;

    // Operation codes carried in the func field.
    localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [2:0] FN_PUSH_REAR  = 3'd1;
    localparam logic [2:0] FN_POP_FRONT  = 3'd2;
    localparam logic [2:0] FN_POP_REAR   = 3'd3;
    localparam logic [2:0] FN_DELETE     = 3'd4;
    localparam logic [2:0] FN_READ       = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] value;
        logic [3:0]  index;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic [31:0] front_value;
        logic [31:0] rear_value;
        logic [4:0]  count;
    } t_out_beat;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic shr;      // push front: every cell takes its left neighbor
        logic shl;      // pop front: every cell takes its right neighbor
        logic del;      // delete: cells at or after the first match take the right neighbor
        logic wr_rear;  // push rear: the cell just past the tail loads the key
    } t_cell_ctl;

endpackage

// ----- design/bdq_cell.sv -----
module bdq_cell #(
    parameter int WIDTH = 32,
    parameter int CW    = 5,
    parameter int POS   = 0
) (
    input  logic               i_clk,
    input  bdq_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]      i_count,
    input  logic [3:0]         i_index,
    input  logic [WIDTH-1:0]   i_key,
    input  logic [WIDTH-1:0]   i_left,
    input  logic [WIDTH-1:0]   i_right,
    input  logic               i_hit,
    output logic               o_hit,
    input  logic [WIDTH-1:0]   i_rd,
    output logic [WIDTH-1:0]   o_rd,
    input  logic [WIDTH-1:0]   i_tail,
    output logic [WIDTH-1:0]   o_tail,
    output logic [WIDTH-1:0]   o_data
);
    import bdq_pkg::*;

    logic [WIDTH-1:0] r_data;
    logic [WIDTH-1:0] n_data;
    logic             w_occ;
    logic             w_is_tail;
    logic             w_is_wpos;
    logic             w_is_rd;

    // Position decode against the current fill count and the read index.
    assign w_occ     = (POS < int'(i_count));
    assign w_is_tail = ((POS + 1) == int'(i_count));
    assign w_is_wpos = (POS == int'(i_count));
    assign w_is_rd   = w_occ && (POS == int'(i_index));

    // The match flag ripples from the front: set once any occupied cell so far matched.
    assign o_hit = i_hit | (w_occ && (r_data == i_key));

    // Read and tail buses collect the one selected cell's word along the chain.
    assign o_rd   = i_rd | (w_is_rd ? r_data : '0);
    assign o_tail = i_tail | (w_is_tail ? r_data : '0);
    assign o_data = r_data;

    // Next word: shift, close the gap behind a deleted element, or load at the rear.
    always_comb begin
        n_data = r_data;
        if (i_ctl.shr) begin
            n_data = i_left;
        end else if (i_ctl.shl) begin
            n_data = i_right;
        end else if (i_ctl.del && o_hit && w_occ) begin
            n_data = i_right;
        end else if (i_ctl.wr_rear && w_is_wpos) begin
            n_data = i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

// ----- design/bounded_deque_with_search_delete_unit.sv -----
// The result beat is registered and valid in the cycle after its input beat is accepted.
// Throughput: one operation per cycle unless a held result stalls; every cell compares and shifts in the same cycle,
// so the cycle time is set by the match flag that ripples through all DEPTH cells.
// A new beat is taken while the held result is being taken in the same cycle.
// Reset clears the fill count and the output valid; cell words are unknown until pushed.
module bounded_deque_with_search_delete_unit #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bdq_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bdq_pkg::t_out_beat o_out_data
);
    import bdq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             r_valid;
    logic [1:0]       r_status;
    logic [1:0]       n_status;
    logic [31:0]      r_read;
    logic [31:0]      n_read;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    logic             w_rd_ok;
    logic [WIDTH-1:0] w_key;
    t_cell_ctl        w_ctl;

    logic [WIDTH-1:0] w_data [DEPTH];
    logic [DEPTH:0]   w_hit;
    logic [WIDTH-1:0] w_rd   [DEPTH+1];
    logic [WIDTH-1:0] w_tail [DEPTH+1];

    // Handshake: the output register frees up when its beat is taken.
    assign o_in_stall = r_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    assign w_key   = WIDTH'(64'(i_in_data.value));
    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);
    assign w_rd_ok = (int'(i_in_data.index) < int'(r_count));

    // Commands to the chain: pushes only when not full, pop front only when not empty, delete always.
    always_comb begin
        w_ctl         = '0;
        w_ctl.shr     = w_accept && (i_in_data.func == FN_PUSH_FRONT) && !w_full;
        w_ctl.wr_rear = w_accept && (i_in_data.func == FN_PUSH_REAR) && !w_full;
        w_ctl.shl     = w_accept && (i_in_data.func == FN_POP_FRONT) && !w_empty;
        w_ctl.del     = w_accept && (i_in_data.func == FN_DELETE);
    end

    // Chain of cells, front at position zero.
    assign w_hit[0]  = 1'b0;
    assign w_rd[0]   = '0;
    assign w_tail[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WIDTH-1:0] w_left;
        logic [WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_key;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        bdq_cell #(
            .WIDTH (WIDTH),
            .CW    (CW),
            .POS   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_count (r_count),
            .i_index (i_in_data.index),
            .i_key   (w_key),
            .i_left  (w_left),
            .i_right (w_right),
            .i_hit   (w_hit[g]),
            .o_hit   (w_hit[g+1]),
            .i_rd    (w_rd[g]),
            .o_rd    (w_rd[g+1]),
            .i_tail  (w_tail[g]),
            .o_tail  (w_tail[g+1]),
            .o_data  (w_data[g])
        );
    end

    // Status, read word and fill count of the accepted operation.
    always_comb begin
        n_count  = r_count;
        n_status = ST_MISS;
        n_read   = '0;
        case (i_in_data.func)
            FN_PUSH_FRONT, FN_PUSH_REAR: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_DONE;
                    n_count  = r_count + CW'(1);
                end
            end
            FN_POP_FRONT, FN_POP_REAR: begin
                if (!w_empty) begin
                    n_status = ST_DONE;
                    n_count  = r_count - CW'(1);
                end
            end
            FN_DELETE: begin
                if (w_hit[DEPTH]) begin
                    n_status = ST_DONE;
                    n_count  = r_count - CW'(1);
                end
            end
            FN_READ: begin
                if (w_rd_ok) begin
                    n_status = ST_DONE;
                    n_read   = 32'(64'(w_rd[DEPTH]));
                end
            end
            default: begin
                n_status = ST_MISS;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_read   <= n_read;
        end
    end

    // Front, rear and count come straight from the state, which holds while a beat waits.
    assign o_out_valid            = r_valid;
    assign o_out_data.status      = r_status;
    assign o_out_data.read_value  = r_read;
    assign o_out_data.front_value = w_empty ? '0 : 32'(64'(w_data[0]));
    assign o_out_data.rear_value  = 32'(64'(w_tail[DEPTH]));
    assign o_out_data.count       = 5'(r_count);

endmodule

// ----- design/bdq_checker.sv -----
module bdq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input bdq_pkg::t_out_beat o_out_data
);
    import bdq_pkg::*;

`include "bounded_deque_with_search_delete_unit_macros.svh"

    logic w_empty;
    logic w_single;
    logic w_read_word;
    logic w_refused;
    logic w_held;
    logic w_ends_zero;
    logic w_ends_same;
    logic w_done;

    // Conditions seen on the result port.
    assign w_empty     = o_out_valid && (o_out_data.count == 5'd0);
    assign w_single    = o_out_valid && (o_out_data.count == 5'd1);
    assign w_read_word = o_out_valid && (o_out_data.read_value != 32'd0);
    assign w_refused   = o_out_valid && (o_out_data.status == ST_FULL);
    assign w_held      = o_out_valid && i_out_stall;
    assign w_ends_zero = (o_out_data.front_value == 32'd0) && (o_out_data.rear_value == 32'd0);
    assign w_ends_same = (o_out_data.front_value == o_out_data.rear_value);
    assign w_done      = (o_out_data.status == ST_DONE);

    // An empty store reports no front and no rear element.
    `BDQ_ASSERT_NOW(a_empty_zero, w_empty, w_ends_zero, "empty store reports an element")

    // With one element the front and the rear are the same word.
    `BDQ_ASSERT_NOW(a_single_same, w_single, w_ends_same, "single element with unequal ends")

    // A read word only comes with a completed operation.
    `BDQ_ASSERT_NOW(a_read_done, w_read_word, w_done, "read word without done status")

    // A refused push leaves the store unchanged and only happens on a full store, so at a nonzero count.
    `BDQ_ASSERT_NOW(a_full_nonzero, w_refused, o_out_data.count != 5'd0, "full status on empty store")

    // A waiting result beat holds until it is taken.
    `BDQ_ASSERT_NEXT(a_out_hold, w_held, o_out_valid && $stable(o_out_data), "held result changed")

endmodule

bind bounded_deque_with_search_delete_unit bdq_checker u_bdq_checker (.*);

// ----- sim/bounded_deque_with_search_delete_unit_test.sv -----
`timescale 1ns / 1ps

module bounded_deque_with_search_delete_unit_test;
    import bdq_pkg::*;

    localparam int STORE_DEPTH     = 16;
    localparam int QUIET_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int REPORT_LIMIT    = 10;

    // The two function codes that the block must ignore.
    localparam logic [2:0] FN_UNUSED_LO = 3'd6;
    localparam logic [2:0] FN_UNUSED_HI = 3'd7;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_data;

    // Predicted store contents, front first, and the results still owed by the block.
    logic [31:0] deque_words[$];
    t_out_beat   result_expect_q[$];
    logic [31:0] value_pool[8];

    bit no_idle      = 1'b0;
    int hold_request = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int fail_count   = 0;
    int beats_sent   = 0;
    int results_checked = 0;
    int full_refusals   = 0;
    int miss_results    = 0;
    int peak_fill       = 0;
    int func_seen[8]    = '{default: 0};

    bounded_deque_with_search_delete_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // Apply one operation to the predicted store and return the result it should give.
    function automatic t_out_beat deque_apply(t_in_beat b);
        t_out_beat r;
        int        hit;
        r        = '0;
        r.status = ST_MISS;
        hit      = -1;
        case (b.func)
            FN_PUSH_FRONT: begin
                if (deque_words.size() >= STORE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    deque_words.push_front(b.value);
                    r.status = ST_DONE;
                end
            end
            FN_PUSH_REAR: begin
                if (deque_words.size() >= STORE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    deque_words.push_back(b.value);
                    r.status = ST_DONE;
                end
            end
            FN_POP_FRONT: begin
                if (deque_words.size() > 0) begin
                    void'(deque_words.pop_front());
                    r.status = ST_DONE;
                end
            end
            FN_POP_REAR: begin
                if (deque_words.size() > 0) begin
                    void'(deque_words.pop_back());
                    r.status = ST_DONE;
                end
            end
            FN_DELETE: begin
                // Only the first match from the front is removed.
                foreach (deque_words[i]) begin
                    if (hit < 0 && deque_words[i] == b.value) hit = i;
                end
                if (hit >= 0) begin
                    deque_words.delete(hit);
                    r.status = ST_DONE;
                end
            end
            FN_READ: begin
                if (int'(b.index) < deque_words.size()) begin
                    r.read_value = deque_words[b.index];
                    r.status     = ST_DONE;
                end
            end
            default: ;
        endcase
        r.count = 5'(deque_words.size());
        if (deque_words.size() > 0) begin
            r.front_value = deque_words[0];
            r.rear_value  = deque_words[deque_words.size() - 1];
        end
        return r;
    endfunction

    function automatic t_in_beat mk_beat(logic [2:0] f, logic [31:0] v, logic [3:0] x);
        t_in_beat b;
        b.func  = f;
        b.value = v;
        b.index = x;
        return b;
    endfunction

    // Mostly values from a small pool so that deletes hit and duplicates occur.
    function automatic logic [31:0] pool_value();
        if ($urandom_range(99) < 70) return value_pool[$urandom_range(7)];
        return $urandom();
    endfunction

    // Random operation, biased toward pushes while growing and removals while shrinking.
    function automatic t_in_beat random_beat(bit grow);
        t_in_beat b;
        int       pick;
        int       sz;
        pick    = $urandom_range(99);
        sz      = deque_words.size();
        b.value = pool_value();
        b.index = 4'($urandom_range(15));
        if (pick < (grow ? 28 : 8))        b.func = FN_PUSH_FRONT;
        else if (pick < (grow ? 56 : 16))  b.func = FN_PUSH_REAR;
        else if (pick < (grow ? 63 : 36))  b.func = FN_POP_FRONT;
        else if (pick < (grow ? 70 : 56))  b.func = FN_POP_REAR;
        else if (pick < (grow ? 80 : 78))  b.func = FN_DELETE;
        else if (pick < 97)                b.func = FN_READ;
        else                               b.func = $urandom_range(1) ? FN_UNUSED_HI : FN_UNUSED_LO;
        // Steer most deletes and reads onto stored elements.
        if (b.func == FN_DELETE && sz > 0 && $urandom_range(3) != 0)
            b.value = deque_words[$urandom_range(sz - 1)];
        if (b.func == FN_READ && sz > 0 && $urandom_range(3) != 0)
            b.index = 4'($urandom_range(sz - 1));
        return b;
    endfunction

    // Offer one beat, wait for it to be taken, and record the result it should give.
    task automatic send_beat(t_in_beat b);
        t_out_beat r;
        if (!no_idle && $urandom_range(99) < 15) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_in_data  <= b;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        r = deque_apply(b);
        result_expect_q.push_back(r);
        beats_sent++;
        func_seen[b.func]++;
        if (r.status == ST_FULL) full_refusals++;
        if (r.status == ST_MISS) miss_results++;
        if (deque_words.size() > peak_fill) peak_fill = deque_words.size();
    endtask

    // Sender goes quiet until every owed result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (result_expect_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_edges();
        logic [31:0] extreme_words[8];
        logic [31:0] absent;
        bit          hit;
        extreme_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE};
        // Removals and lookups on an empty store all miss, as does an unused code.
        send_beat(mk_beat(FN_POP_FRONT, 32'h0000_0000, 4'd0));
        send_beat(mk_beat(FN_POP_REAR, 32'hFFFF_FFFF, 4'd15));
        send_beat(mk_beat(FN_DELETE, 32'h0000_0000, 4'd0));
        send_beat(mk_beat(FN_READ, 32'h0000_0000, 4'd0));
        send_beat(mk_beat(FN_UNUSED_LO, 32'hFFFF_FFFF, 4'd15));
        // Fill to capacity from both ends.
        for (int i = 0; i < STORE_DEPTH; i++) begin
            send_beat(mk_beat(i[0] ? FN_PUSH_FRONT : FN_PUSH_REAR,
                              i < 8 ? extreme_words[i] : $urandom(), i[3:0]));
        end
        // A full store refuses pushes at either end; the last index is readable.
        send_beat(mk_beat(FN_PUSH_REAR, 32'hDEAD_BEEF, 4'd0));
        send_beat(mk_beat(FN_PUSH_FRONT, 32'h0000_0000, 4'd0));
        send_beat(mk_beat(FN_READ, 32'h0000_0000, 4'd15));
        // Closing a gap in the middle leaves the last index out of range.
        send_beat(mk_beat(FN_DELETE, deque_words[7], 4'd0));
        send_beat(mk_beat(FN_READ, 32'h0000_0000, 4'd15));
        // Delete of a value that is not stored.
        do begin
            absent = $urandom();
            hit    = 1'b0;
            foreach (deque_words[k]) begin
                if (deque_words[k] == absent) hit = 1'b1;
            end
        end while (hit);
        send_beat(mk_beat(FN_DELETE, absent, 4'd0));
    endtask

    // Alternating grow and shrink runs; the opening stretch runs with no idling.
    task automatic test_random_mix(int n_items);
        bit grow;
        int run_left;
        grow     = 1'b0;
        run_left = 0;
        for (int k = 0; k < n_items; k++) begin
            no_idle = (k < 100);
            if (run_left == 0) begin
                grow     = ~grow;
                run_left = $urandom_range(15, 40);
            end
            run_left--;
            send_beat(random_beat(grow));
        end
        no_idle = 1'b0;
    endtask

    // The receiver holds off for a long stretch while beats keep coming, so the block stalls its input.
    task automatic test_receiver_holdoff();
        no_idle      = 1'b1;
        hold_request = HOLD_OFF_CYCLES;
        for (int k = 0; k < 40; k++) send_beat(random_beat(k < 24));
        no_idle = 1'b0;
    endtask

    // Result side: a requested hold-off, no stall while idling is off, else random stall.
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (no_idle) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 18);
        end
    end

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("mismatch in %s of result %0d: expected %h, got %h",
                         fname, results_checked, want, got);
        end
    endtask

    // Compare every taken result beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_expect_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("result beat with nothing expected: %h", o_out_data);
            end else begin
                want = result_expect_q.pop_front();
                check_field("status", 32'(want.status), 32'(o_out_data.status));
                check_field("read_value", want.read_value, o_out_data.read_value);
                check_field("front_value", want.front_value, o_out_data.front_value);
                check_field("rear_value", want.rear_value, o_out_data.rear_value);
                check_field("count", 32'(want.count), 32'(o_out_data.count));
                results_checked++;
            end
        end
    end

    // End the run if no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, result_expect_q.size());
            $display("bounded_deque_with_search_delete_unit regression: fail");
            $finish;
        end
    end

    initial begin
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        for (int p = 2; p < 8; p++) value_pool[p] = $urandom();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        wait_drained();
        test_random_mix(380);
        test_receiver_holdoff();
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("covered %0d beats: push front %0d, push rear %0d, pop front %0d, pop rear %0d, delete %0d, read %0d, ignored codes %0d",
                 beats_sent, func_seen[FN_PUSH_FRONT], func_seen[FN_PUSH_REAR],
                 func_seen[FN_POP_FRONT], func_seen[FN_POP_REAR], func_seen[FN_DELETE],
                 func_seen[FN_READ], func_seen[FN_UNUSED_LO] + func_seen[FN_UNUSED_HI]);
        $display("%0d results checked, %0d refused as full, %0d misses, peak fill %0d, %0d failures",
                 results_checked, full_refusals, miss_results, peak_fill, fail_count);
        if (fail_count == 0)
            $display("bounded_deque_with_search_delete_unit regression: pass");
        else
            $display("bounded_deque_with_search_delete_unit regression: fail");
        $finish;
    end

endmodule
